// File: rtl/assert_macros.svh
// assertion macros for the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BAMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BAMS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BAMS_ASSERT(lbl, prop, msg)
`define BAMS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/bams_pkg.sv
// shared types and constants of the bit aligned byte match scanner
package bams_pkg;
	localparam int BYTE_W = 8;
	localparam int SHIFTS = 8;
	localparam int CTX_W = 48;
	localparam int HIST_W = 64;
	localparam int SEEN_W = 4;
	localparam int SHIFT_W = 3;
	localparam logic [SEEN_W-1:0] FULL_COUNT = 4'd8;

	typedef struct packed {
		logic [SHIFTS-1:0] mask;
		logic [HIST_W-1:0] hist;
	} bams_entry_t;
endpackage

// File: rtl/bams_if.sv
// stream and result channel interfaces
interface bams_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       block_start;

	modport source(output valid, data_byte, block_start, input ready);
	modport sink(input valid, data_byte, block_start, output ready);
endinterface

interface bams_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  bit_shift;
	logic [15:0] context_high;
	logic [31:0] context_low;
	logic        last;

	modport source(output valid, bit_shift, context_high, context_low, last, input ready);
	modport sink(input valid, bit_shift, context_high, context_low, last, output ready);
endinterface

// File: rtl/bams_front.sv
// front end: history, target register and per-shift match classification
module bams_front import bams_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [BYTE_W-1:0]   cfg_wdata,
	bams_stream_if.sink         stream,
	input  logic                q_full,
	output logic                q_push,
	output bams_entry_t         q_entry
);
	logic [BYTE_W-1:0] target_q;
	logic [HIST_W-1:0] history_q;
	logic [SEEN_W-1:0] seen_q;
	logic [HIST_W-1:0] hist_eff;
	logic [SEEN_W-1:0] seen_eff;
	logic [2*BYTE_W-1:0] pair;
	logic [SHIFTS-1:0] mask;
	logic accept;

	assign stream.ready = !q_full;
	assign accept = stream.valid && stream.ready;
	assign hist_eff = stream.block_start ? '0 : history_q;
	assign seen_eff = stream.block_start ? '0 : seen_q;
	assign pair = {hist_eff[BYTE_W-1:0], stream.data_byte};

	always_comb begin
		for (int s = 0; s < SHIFTS; s++) begin
			mask[s] = (seen_eff == FULL_COUNT) && (pair[2*BYTE_W-1-s -: BYTE_W] == target_q);
		end
	end

	assign q_push = accept && (|mask);
	assign q_entry = '{mask: mask, hist: hist_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			history_q <= '0;
			seen_q <= '0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (accept) begin
				history_q <= {hist_eff[HIST_W-BYTE_W-1:0], stream.data_byte};
				seen_q <= (seen_eff == FULL_COUNT) ? FULL_COUNT : seen_eff + 1'b1;
			end
		end
	end
endmodule

// File: rtl/bams_queue.sv
// short queue of classified words between front and back
`include "assert_macros.svh"
module bams_queue import bams_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bams_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        nonempty,
	output bams_entry_t head
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bams_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`BAMS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count above depth")
	`BAMS_ASSERT(a_cnt_up, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count lost push")
	`BAMS_ASSERT_NEVER(a_pop_empty, pop && !nonempty, "pop from empty queue")
	`BAMS_ASSERT(a_head_live, nonempty |-> (head.mask != '0), "queued word has no match")
endmodule

// File: rtl/bams_back.sv
// back end: walks matching shifts of the head word and fills the output register
module bams_back import bams_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  bams_entry_t head,
	output logic        q_pop,
	bams_result_if.source result
);
	logic [SHIFTS-1:0]  done_q;
	logic [SHIFTS-1:0]  live;
	logic [SHIFTS-1:0]  bit_sel;
	logic [SHIFTS-1:0]  rest;
	logic [SHIFT_W-1:0] sel;
	logic [HIST_W-1:0]  shifted;
	logic               emit;
	logic               out_valid_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [CTX_W-1:0]   ctx_q;
	logic               last_q;

	assign live = head.mask & ~done_q;

	always_comb begin
		sel = '0;
		for (int i = SHIFTS - 1; i >= 0; i--) begin
			if (live[i]) begin
				sel = SHIFT_W'(i);
			end
		end
	end

	assign bit_sel = SHIFTS'(1) << sel;
	assign rest = live & ~bit_sel;
	assign shifted = head.hist << sel;
	assign emit = q_nonempty && (!out_valid_q || result.ready);
	assign q_pop = emit && (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				done_q <= q_pop ? '0 : (done_q | bit_sel);
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			shift_q <= sel;
			ctx_q <= shifted[CTX_W+BYTE_W-1:BYTE_W];
			last_q <= (rest == '0);
		end
	end

	assign result.valid = out_valid_q;
	assign result.bit_shift = shift_q;
	assign result.context_high = ctx_q[CTX_W-1:32];
	assign result.context_low = ctx_q[31:0];
	assign result.last = last_q;
endmodule

// File: rtl/bit_aligned_byte_match_scanner.sv
// top level of the bit aligned byte match scanner
//
// channel   dir   word
// stream    in    data_byte[7:0], block_start
// result    out   bit_shift[2:0], context_high[15:0], context_low[31:0], last
// cfg       in    cfg_we, cfg_wdata[7:0] (target byte)
//
// one byte accepted per cycle while the match queue has room
// a byte with k matches gives k results from the back end, one result per cycle while the result channel is ready
// the output register emits one result per cycle while the result channel is ready, set by the back end walker
// stream stalls only when QUEUE_DEPTH words with matches are waiting
// arst_n clears history, byte count, target byte, queue and output valid
module bit_aligned_byte_match_scanner import bams_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	bams_stream_if.sink stream,
	bams_result_if.source result
);
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_nonempty;
	bams_entry_t q_entry;
	bams_entry_t q_head;

	bams_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream    (stream),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_entry)
	);

	bams_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.nonempty   (q_nonempty),
		.head       (q_head)
	);

	bams_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.head       (q_head),
		.q_pop      (q_pop),
		.result     (result)
	);
endmodule

// File: tb/tb_bit_aligned_byte_match_scanner.sv
`timescale 1ns / 100ps
// self-checking testbench of the bit aligned byte match scanner with its own match predictor
module tb_bit_aligned_byte_match_scanner;
	import bams_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int RAND_PHASE_BYTES = 72;
	localparam int MAX_PRINTS = 30;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              block_start;
	} stream_word_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] bit_shift;
		logic [15:0]        context_high;
		logic [31:0]        context_low;
		logic               last;
	} match_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	bams_stream_if stream_ch();
	bams_result_if result_ch();

	bit_aligned_byte_match_scanner u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.stream(stream_ch),
		.result(result_ch)
	);

	stream_word_t byte_q[$];
	match_t match_q[$];

	logic [HIST_W-1:0] hist_model;
	logic [SEEN_W-1:0] seen_model;
	logic [BYTE_W-1:0] tgt_model;
	logic [BYTE_W-1:0] last_queued;

	int bytes_sent;
	int bytes_taken;
	int matches_checked;
	int err_cnt;
	int target_writes;
	int gap_left;
	int stall_left;
	bit idle_on;
	bit in_fire;
	stream_word_t drv_word;
	match_t got_m;
	match_t exp_m;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	// expected matches of one accepted stream word
	task automatic predict_matches(input logic [BYTE_W-1:0] nb, input logic blk);
		logic [15:0] pair;
		logic [SHIFTS-1:0] hits;
		logic [HIST_W-1:0] moved;
		match_t m;
		int top;
		if (blk) begin
			hist_model = '0;
			seen_model = '0;
		end
		if (seen_model >= FULL_COUNT) begin
			pair = {hist_model[7:0], nb};
			top = -1;
			for (int s = 0; s < SHIFTS; s++) begin
				hits[s] = (pair[15-s -: 8] == tgt_model);
				if (hits[s])
					top = s;
			end
			for (int s = 0; s < SHIFTS; s++) begin
				if (hits[s]) begin
					moved = hist_model << s;
					m.bit_shift = SHIFT_W'(s);
					m.context_high = moved[55:40];
					m.context_low = moved[39:8];
					m.last = (s == top);
					match_q.insert(match_q.size(), m);
				end
			end
		end
		hist_model = {hist_model[HIST_W-BYTE_W-1:0], nb};
		if (seen_model < FULL_COUNT)
			seen_model++;
	endtask

	always @(posedge clk) begin
		in_fire = arst_n && stream_ch.valid && stream_ch.ready;
		if (in_fire) begin
			predict_matches(stream_ch.data_byte, stream_ch.block_start);
			bytes_taken++;
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got_m.bit_shift = result_ch.bit_shift;
			got_m.context_high = result_ch.context_high;
			got_m.context_low = result_ch.context_low;
			got_m.last = result_ch.last;
			if (match_q.size() == 0) begin
				report($sformatf("unexpected result shift %0d", got_m.bit_shift));
			end else begin
				exp_m = match_q.pop_front();
				matches_checked++;
				if (got_m.bit_shift !== exp_m.bit_shift)
					report($sformatf("bit_shift got %0d exp %0d",
						got_m.bit_shift, exp_m.bit_shift));
				if (got_m.context_high !== exp_m.context_high)
					report($sformatf("context_high got %h exp %h",
						got_m.context_high, exp_m.context_high));
				if (got_m.context_low !== exp_m.context_low)
					report($sformatf("context_low got %h exp %h",
						got_m.context_low, exp_m.context_low));
				if (got_m.last !== exp_m.last)
					report($sformatf("last got %b exp %b", got_m.last, exp_m.last));
			end
		end
	end

	// stream driver
	always @(negedge clk) begin
		if (!arst_n) begin
			stream_ch.valid <= 1'b0;
		end else if (!stream_ch.valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				stream_ch.valid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				drv_word = byte_q.pop_front();
				stream_ch.valid <= 1'b1;
				stream_ch.data_byte <= drv_word.data_byte;
				stream_ch.block_start <= drv_word.block_start;
				if (idle_on && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 11);
			end else begin
				stream_ch.valid <= 1'b0;
			end
		end
	end

	// result back pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 10);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	task automatic queue_byte(input logic [BYTE_W-1:0] d, input logic blk);
		stream_word_t w;
		w.data_byte = d;
		w.block_start = blk;
		byte_q.insert(byte_q.size(), w);
		last_queued = d;
		bytes_sent++;
	endtask

	task automatic wait_idle();
		while (bytes_taken != bytes_sent || match_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_target(input logic [7:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		tgt_model = value;
		target_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// blocks of random bytes, many with the target planted at a random bit offset
	task automatic gen_blocks(input int n_bytes);
		int made;
		int blen;
		int pos;
		int s;
		logic blk;
		logic [15:0] pair;
		made = 0;
		while (made < n_bytes) begin
			blen = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			if (blen > n_bytes - made)
				blen = n_bytes - made;
			blk = ($urandom_range(0, 7) != 0);
			pos = 0;
			while (pos < blen) begin
				case ($urandom_range(0, 7)) inside
					[0:1]: begin
						pair = 16'($urandom);
						s = $urandom_range(0, 7);
						pair[15-s -: 8] = tgt_model;
						queue_byte(pair[15:8], blk);
						queue_byte(pair[7:0], 1'b0);
						pos += 2;
					end
					2: begin
						queue_byte(last_queued, blk);
						pos++;
					end
					default: begin
						queue_byte(BYTE_W'($urandom), blk);
						pos++;
					end
				endcase
				blk = 1'b0;
			end
			made += pos;
		end
	endtask

	initial begin
		logic [7:0] targets[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		stream_ch.valid = 1'b0;
		stream_ch.data_byte = '0;
		stream_ch.block_start = 1'b0;
		result_ch.ready = 1'b0;
		hist_model = '0;
		seen_model = '0;
		tgt_model = '0;
		last_queued = '0;
		bytes_sent = 0;
		bytes_taken = 0;
		matches_checked = 0;
		err_cnt = 0;
		target_writes = 0;
		gap_left = 0;
		stall_left = 0;
		idle_on = 1'b1;
		in_fire = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset target of zero: zero bytes warm up, then every shift matches
		for (int i = 0; i < 10; i++)
			queue_byte(8'h00, i == 0);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hff, 1'b0);

		write_target(8'hff);
		for (int i = 0; i < 9; i++)
			queue_byte(8'hff, i == 0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'hfe, 1'b0);

		targets[0] = 8'h00;
		targets[1] = 8'($urandom);
		targets[2] = 8'($urandom);
		targets[3] = 8'hff;
		targets[4] = 8'($urandom);
		targets[5] = 8'($urandom);
		for (int p = 0; p < 6; p++) begin
			write_target(targets[p]);
			if (p == 5)
				idle_on = 1'b0;
			gen_blocks(RAND_PHASE_BYTES);
		end
		wait_idle();

		$display("run covered %0d stream bytes over %0d target settings", bytes_sent,
			target_writes + 1);
		$display("%0d match results checked, %0d left waiting", matches_checked,
			match_q.size());
		if (err_cnt == 0 && match_q.size() == 0) begin
			$display("bit_aligned_byte_match_scanner verification clean");
		end else begin
			$display("bit_aligned_byte_match_scanner verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout waiting for the scanner");
		$display("bit_aligned_byte_match_scanner verification failed");
		$finish;
	end
endmodule

// File: bit_aligned_byte_match_scanner.f
+incdir+rtl
rtl/bams_pkg.sv
rtl/bams_if.sv
rtl/bams_front.sv
rtl/bams_queue.sv
rtl/bams_back.sv
rtl/bit_aligned_byte_match_scanner.sv
tb/tb_bit_aligned_byte_match_scanner.sv
